>>> hw/rtl/dspq_pkg.sv
// Shared types and constants for the dock status poll qualifier.
`timescale 1ns / 1ps

package dspq_pkg;

    // Defaults for the top-level parameters
    localparam int DEBOUNCE_TICKS_DEF = 5;
    localparam int CYCLE_TICKS_DEF    = 10;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHUTDOWN_TO_MAIN   = 3'd0,
        CFG_SECURE_RESET_EN    = 3'd1,
        CFG_DOCK_RXD_DETECT    = 3'd2,
        CFG_IPOD_LINE_PRESENT  = 3'd3,
        CFG_TMC_LINE_PRESENT   = 3'd4,
        CFG_IGNITION_HOLD      = 3'd5,
        CFG_BUTTON_HOLD        = 3'd6,
        CFG_SECURE_RESET_TICKS = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] IGN_HOLD_RST  = 8'd25;
    localparam logic [CFG_DATA_W-1:0] BTN_HOLD_RST  = 8'd2;
    localparam logic [CFG_DATA_W-1:0] SRST_HOLD_RST = 8'd50;

    // Hold timers: 9 bits, all ones means idle
    localparam int TMR_W = 9;
    localparam logic [TMR_W-1:0] TMR_IDLE = '1;

    // Status word
    localparam int FLAGS_W  = 14;
    localparam int NUM_LINES = 3;

    // Host operation bits
    localparam int OP_CLR_ONOFF  = 0;
    localparam int OP_ACK_CHANGE = 1;
    localparam int OP_ACK_DISK   = 2;
    localparam int OP_PWR_CYCLE  = 3;

    // Line indices
    localparam int LINE_IPOD = 0;
    localparam int LINE_TMC  = 1;
    localparam int LINE_DOCK = 2;

    typedef struct packed {
        logic       dock_power_avail;
        logic [5:0] accessory_levels;
        logic       low_vcc_peak;
        logic       low_vcc_level;
        logic [2:0] rxd_levels;
        logic [2:0] break_seen;
        logic       car_docked;
        logic       ext_power;
        logic       button_level;
        logic       hdd_led;
        logic [3:0] host_ops;
        logic [7:0] dock_state_in;
    } t_item;

    typedef struct packed {
        logic [FLAGS_W-1:0] status_flags;
        logic [7:0]         dock_state_out;
        logic               status_changed;
        logic               disk_access_started;
        logic               dock_power_drive;
        logic               secure_reset_request;
    } t_result;

    // Control of one hold timer for one tick
    typedef struct packed {
        logic load;       // reload from the hold value
        logic stop;       // force idle
        logic run;        // count down
        logic fire_idle;  // an idle timer fires while running
    } t_tmr_ctl;

endpackage

>>> hw/rtl/dspq_in_if.sv
// Poll tick channel: valid/ready plus the tick fields.
`timescale 1ns / 1ps

interface dspq_in_if;
    logic       valid;
    logic       ready;
    logic       dock_power_avail;
    logic [5:0] accessory_levels;
    logic       low_vcc_peak;
    logic       low_vcc_level;
    logic [2:0] rxd_levels;
    logic [2:0] break_seen;
    logic       car_docked;
    logic       ext_power;
    logic       button_level;
    logic       hdd_led;
    logic [3:0] host_ops;
    logic [7:0] dock_state_in;

    modport source (
        output valid, dock_power_avail, accessory_levels, low_vcc_peak, low_vcc_level,
               rxd_levels, break_seen, car_docked, ext_power, button_level, hdd_led,
               host_ops, dock_state_in,
        input  ready
    );

    modport sink (
        input  valid, dock_power_avail, accessory_levels, low_vcc_peak, low_vcc_level,
               rxd_levels, break_seen, car_docked, ext_power, button_level, hdd_led,
               host_ops, dock_state_in,
        output ready
    );
endinterface

>>> hw/rtl/dspq_out_if.sv
// Status result channel: valid/ready plus the result fields.
`timescale 1ns / 1ps

interface dspq_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] status_flags;
    logic [7:0]  dock_state_out;
    logic        status_changed;
    logic        disk_access_started;
    logic        dock_power_drive;
    logic        secure_reset_request;

    modport source (
        output valid, status_flags, dock_state_out, status_changed, disk_access_started,
               dock_power_drive, secure_reset_request,
        input  ready
    );

    modport sink (
        input  valid, status_flags, dock_state_out, status_changed, disk_access_started,
               dock_power_drive, secure_reset_request,
        output ready
    );
endinterface

>>> hw/rtl/dspq_line_qual.sv
// RXD line connection qualifier: high/low tick debounce with break disconnect.
`timescale 1ns / 1ps

module dspq_line_qual #(
    parameter int DEBOUNCE_TICKS = dspq_pkg::DEBOUNCE_TICKS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  logic i_en,
    input  logic i_force,
    input  logic i_level,
    input  logic i_brk,
    output logic o_conn,
    output logic o_conn_next
);
    localparam int LO_W = $clog2(DEBOUNCE_TICKS + 2);
    localparam int HI_W = $clog2(DEBOUNCE_TICKS + 1);
    localparam logic [LO_W-1:0] LoMax = LO_W'(DEBOUNCE_TICKS);
    localparam logic [HI_W-1:0] HiMax = HI_W'(DEBOUNCE_TICKS);

    logic            r_conn, n_conn;
    logic [LO_W-1:0] r_lo, n_lo, lo_inc;
    logic [HI_W-1:0] r_hi, n_hi;

    always_comb begin
        n_conn = r_conn;
        n_lo   = r_lo;
        n_hi   = r_hi;
        // low count saturates one past the debounce limit
        lo_inc = (r_lo <= LoMax) ? r_lo + LO_W'(1) : r_lo;
        if (i_force) begin
            n_conn = 1'b1;
        end else if (i_en) begin
            if (r_conn) begin
                if (i_brk) begin
                    if (!i_level) begin
                        n_conn = 1'b0;
                    end
                end else if (!i_level) begin
                    n_lo = lo_inc;
                    if (lo_inc > LoMax) begin
                        n_conn = 1'b0;
                    end
                end else begin
                    n_lo = '0;
                end
            end else begin
                if (!i_level) begin
                    n_hi = '0;
                end else if (r_hi < HiMax) begin
                    n_hi = r_hi + HI_W'(1);
                end else begin
                    n_conn = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn <= 1'b0;
            r_lo   <= '0;
            r_hi   <= '0;
        end else if (i_step) begin
            r_conn <= n_conn;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
        end
    end

    assign o_conn      = r_conn;
    assign o_conn_next = n_conn;
endmodule

>>> hw/rtl/dspq_hold_timer.sv
// Reloadable hold countdown with an idle code; fires when it runs out, or while idle if fire_idle is set.
`timescale 1ns / 1ps

module dspq_hold_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  dspq_pkg::t_tmr_ctl            i_ctl,
    input  logic [dspq_pkg::CFG_DATA_W-1:0] i_load_val,
    output logic                          o_fire
);
    import dspq_pkg::*;

    logic [TMR_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_cnt  = r_cnt;
        o_fire = 1'b0;
        if (i_ctl.load) begin
            n_cnt = TMR_W'(i_load_val);
        end else if (i_ctl.stop) begin
            n_cnt = TMR_IDLE;
        end else if (i_ctl.run) begin
            if (r_cnt == TMR_IDLE) begin
                o_fire = i_ctl.fire_idle;
            end else if (r_cnt != '0) begin
                n_cnt = r_cnt - TMR_W'(1);
            end else begin
                n_cnt  = TMR_IDLE;
                o_fire = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= TMR_IDLE;
        end else if (i_step) begin
            r_cnt <= n_cnt;
        end
    end
endmodule

>>> hw/rtl/dock_status_poll_qualifier_core.sv
// Top level of the dock status poll qualifier: tick register, status update, result register.
// Path: a transferred tick is held in the tick register, and its result is loaded into the
//   result register when the tick advances, from where the result can transfer.
// Throughput: one tick per cycle; the output register lets the next tick in while a
//   result waits, the input register stalls only while the output is held.
// Reset: synchronous, active low; status, line counters, latches clear, hold timers go
//   idle, dock power drive comes up enabled, registers take their documented values.
`timescale 1ns / 1ps

module dock_status_poll_qualifier_core #(
    parameter int DEBOUNCE_TICKS = dspq_pkg::DEBOUNCE_TICKS_DEF,  // 1..7
    parameter int CYCLE_TICKS    = dspq_pkg::CYCLE_TICKS_DEF      // 1..15
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dspq_in_if.sink                         i_item,
    dspq_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [dspq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dspq_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import dspq_pkg::*;

    localparam int PC_W = $clog2(CYCLE_TICKS + 1);
    localparam logic [PC_W-1:0] CycleLoad = PC_W'(CYCLE_TICKS);

    // ---------------------------------------------------------------- config
    logic                  r_cfg_main, r_cfg_srst_en, r_cfg_dock_det;
    logic                  r_cfg_ipod, r_cfg_tmc;
    logic [CFG_DATA_W-1:0] r_cfg_ign_ticks, r_cfg_btn_ticks, r_cfg_srst_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_main       <= 1'b0;
            r_cfg_srst_en    <= 1'b0;
            r_cfg_dock_det   <= 1'b0;
            r_cfg_ipod       <= 1'b0;
            r_cfg_tmc        <= 1'b0;
            r_cfg_ign_ticks  <= IGN_HOLD_RST;
            r_cfg_btn_ticks  <= BTN_HOLD_RST;
            r_cfg_srst_ticks <= SRST_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SHUTDOWN_TO_MAIN:   r_cfg_main       <= i_cfg_wdata[0];
                CFG_SECURE_RESET_EN:    r_cfg_srst_en    <= i_cfg_wdata[0];
                CFG_DOCK_RXD_DETECT:    r_cfg_dock_det   <= i_cfg_wdata[0];
                CFG_IPOD_LINE_PRESENT:  r_cfg_ipod       <= i_cfg_wdata[0];
                CFG_TMC_LINE_PRESENT:   r_cfg_tmc        <= i_cfg_wdata[0];
                CFG_IGNITION_HOLD:      r_cfg_ign_ticks  <= i_cfg_wdata;
                CFG_BUTTON_HOLD:        r_cfg_btn_ticks  <= i_cfg_wdata;
                CFG_SECURE_RESET_TICKS: r_cfg_srst_ticks <= i_cfg_wdata;
                default:                r_cfg_main       <= r_cfg_main;
            endcase
        end
    end

    // ------------------------------------------------------- tick register
    // advance: the held tick is applied to the state and its result loaded
    logic  r_in_valid;
    t_item r_in;
    logic  advance;
    logic  r_out_valid;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.dock_power_avail <= i_item.dock_power_avail;
            r_in.accessory_levels <= i_item.accessory_levels;
            r_in.low_vcc_peak     <= i_item.low_vcc_peak;
            r_in.low_vcc_level    <= i_item.low_vcc_level;
            r_in.rxd_levels       <= i_item.rxd_levels;
            r_in.break_seen       <= i_item.break_seen;
            r_in.car_docked       <= i_item.car_docked;
            r_in.ext_power        <= i_item.ext_power;
            r_in.button_level     <= i_item.button_level;
            r_in.hdd_led          <= i_item.hdd_led;
            r_in.host_ops         <= i_item.host_ops;
            r_in.dock_state_in    <= i_item.dock_state_in;
        end
    end

    // --------------------------------------------------- line qualifiers
    logic [NUM_LINES-1:0] line_en, line_force, line_conn, line_next;

    assign line_en    = {r_cfg_dock_det, r_cfg_tmc, r_cfg_ipod};
    // without a dock RXD detect the dock line reads as connected
    assign line_force = {!r_cfg_dock_det, 1'b0, 1'b0};

    for (genvar g = 0; g < NUM_LINES; g++) begin : g_line
        dspq_line_qual #(
            .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
        ) u_line (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_step      (advance),
            .i_en        (line_en[g]),
            .i_force     (line_force[g]),
            .i_level     (r_in.rxd_levels[g]),
            .i_brk       (r_in.break_seen[g]),
            .o_conn      (line_conn[g]),
            .o_conn_next (line_next[g])
        );
    end

    // -------------------------------------------------------- hold timers
    t_tmr_ctl ign_ctl, btn_ctl, srst_ctl;
    logic     ign_fire, btn_fire, srst_fire;

    // ignition: reload while external power present in the dock, idle out of dock
    assign ign_ctl.load      = r_in.car_docked && r_in.ext_power;
    assign ign_ctl.stop      = !r_in.car_docked;
    assign ign_ctl.run       = r_in.car_docked && !r_in.ext_power;
    assign ign_ctl.fire_idle = 1'b0;

    assign btn_ctl.load      = !r_in.button_level;
    assign btn_ctl.stop      = 1'b0;
    assign btn_ctl.run       = r_in.button_level;
    assign btn_ctl.fire_idle = 1'b0;

    // secure reset keeps requesting while the button stays held after expiry
    assign srst_ctl.load      = r_cfg_srst_en && !r_in.button_level;
    assign srst_ctl.stop      = 1'b0;
    assign srst_ctl.run       = r_cfg_srst_en && r_in.button_level;
    assign srst_ctl.fire_idle = 1'b1;

    dspq_hold_timer u_ign_tmr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_ctl      (ign_ctl),
        .i_load_val (r_cfg_ign_ticks),
        .o_fire     (ign_fire)
    );

    dspq_hold_timer u_btn_tmr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_ctl      (btn_ctl),
        .i_load_val (r_cfg_btn_ticks),
        .o_fire     (btn_fire)
    );

    dspq_hold_timer u_srst_tmr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_ctl      (srst_ctl),
        .i_load_val (r_cfg_srst_ticks),
        .o_fire     (srst_fire)
    );

    // ------------------------------------------------------ status update
    logic [7:0]        r_flags_lo, n_flags_lo;
    logic              r_main, n_main;
    logic              r_onoff, n_onoff;
    logic              r_dock_onoff, n_dock_onoff;
    logic              r_changed, n_changed;
    logic              r_disk_prev, n_disk_prev;
    logic              r_disk_started, n_disk_started;
    logic [PC_W-1:0]   r_pc_cnt, n_pc_cnt, pc_loaded;
    logic              r_drive, n_drive;
    logic [FLAGS_W-1:0] flags_old, flags_new;

    always_comb begin
        // host operations act first, so a change in the same tick latches again
        n_onoff        = r_onoff && !r_in.host_ops[OP_CLR_ONOFF];
        n_changed      = r_changed && !r_in.host_ops[OP_ACK_CHANGE];
        n_disk_started = r_disk_started && !r_in.host_ops[OP_ACK_DISK];
        pc_loaded      = r_in.host_ops[OP_PWR_CYCLE] ? CycleLoad : r_pc_cnt;

        // dock power drive only moves while dock supply is present
        n_drive  = r_in.dock_power_avail ? (pc_loaded == '0) : r_drive;
        n_pc_cnt = (pc_loaded != '0) ? pc_loaded - PC_W'(1) : pc_loaded;

        n_flags_lo   = {r_in.low_vcc_level, r_in.low_vcc_peak, r_in.accessory_levels};
        n_main       = r_in.car_docked && r_in.ext_power;
        n_onoff      = n_onoff || (ign_fire && r_cfg_main) || btn_fire;
        n_dock_onoff = r_dock_onoff || (ign_fire && !r_cfg_main);

        n_disk_started = n_disk_started || (r_in.hdd_led && !r_disk_prev);
        n_disk_prev    = r_in.hdd_led;

        flags_old = {r_dock_onoff, r_onoff, r_main, line_conn, r_flags_lo};
        flags_new = {n_dock_onoff, n_onoff, n_main, line_next, n_flags_lo};
        n_changed = n_changed || (flags_new != flags_old);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags_lo     <= '0;
            r_main         <= 1'b0;
            r_onoff        <= 1'b0;
            r_dock_onoff   <= 1'b0;
            r_changed      <= 1'b0;
            r_disk_prev    <= 1'b0;
            r_disk_started <= 1'b0;
            r_pc_cnt       <= '0;
            r_drive        <= 1'b1;
        end else if (advance) begin
            r_flags_lo     <= n_flags_lo;
            r_main         <= n_main;
            r_onoff        <= n_onoff;
            r_dock_onoff   <= n_dock_onoff;
            r_changed      <= n_changed;
            r_disk_prev    <= n_disk_prev;
            r_disk_started <= n_disk_started;
            r_pc_cnt       <= n_pc_cnt;
            r_drive        <= n_drive;
        end
    end

    // ---------------------------------------------------- result register
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.status_flags         <= flags_new;
            r_out.dock_state_out       <= r_in.dock_state_in;
            r_out.status_changed       <= n_changed;
            r_out.disk_access_started  <= n_disk_started;
            r_out.dock_power_drive     <= n_drive;
            r_out.secure_reset_request <= srst_fire;
        end
    end

    assign o_result.valid                = r_out_valid;
    assign o_result.status_flags         = r_out.status_flags;
    assign o_result.dock_state_out       = r_out.dock_state_out;
    assign o_result.status_changed       = r_out.status_changed;
    assign o_result.disk_access_started  = r_out.disk_access_started;
    assign o_result.dock_power_drive     = r_out.dock_power_drive;
    assign o_result.secure_reset_request = r_out.secure_reset_request;
endmodule

>>> hw/rtl/dspq_checker.sv
// Port-level checker for the dock status poll qualifier, bound to the top level.
`timescale 1ns / 1ps

module dspq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    // a transferred tick is to be followed by a valid result on the output
    a_tick_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 i_out_valid)
        else $error("tick transfer without result two cycles later");

    // input only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled while output free");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("pipeline not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_out_valid) && !$past(i_out_ready)) |-> i_out_valid)
        else $error("result dropped while stalled");
endmodule

bind dock_status_poll_qualifier_core dspq_checker u_dspq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);
